// ----- rtl/core/aff_pkg.sv -----
// Shared widths, types and codes for the affine matrix inverse pipeline.
package aff_pkg;

   localparam int AW            = 32;   // element width, signed fixed point
   localparam int ADJ_W         = 65;   // 2x2 minor, exact
   localparam int DET_W         = 97;   // determinant, exact
   localparam int TS_W          = 97;   // adjugate row dotted with translation
   localparam int QW            = 32;   // quotient / result element width
   localparam int DEF_FRAC_BITS = 16;
   localparam int IN_W          = 12 * AW;

   localparam logic [1:0] FIRST_ROW = 2'd0;
   localparam logic [1:0] TRANS_ROW = 2'd3;

   typedef logic signed [AW-1:0]    elem_type;
   typedef logic signed [ADJ_W-1:0] adj_type;
   typedef logic signed [DET_W-1:0] wide_type;

   typedef struct packed {
      adj_type  [8:0] adj;
      wide_type       det;
      wide_type [2:0] tsum;
   } cof_type;

   typedef struct packed {
      logic [1:0] row_index;
      logic       singular;
      logic       last_row;
   } tag_type;

endpackage

// ----- rtl/core/aff_cofactor.sv -----
// Adjugate, determinant and translation dot products, six register stages.
module aff_cofactor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [aff_pkg::IN_W-1:0]    in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output aff_pkg::cof_type            out_cof
);

   localparam int NS = 6;
   localparam int L_IDX [18] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
   localparam int R_IDX [18] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

   logic [NS-1:0] v_ff, v_in, en;

   aff_pkg::elem_type a0_ff [12];
   logic signed [63:0] p1_ff [18];
   aff_pkg::elem_type c1_a_ff [3], c1_t_ff [3];
   aff_pkg::adj_type  adj2_ff [9];
   aff_pkg::elem_type c2_a_ff [3], c2_t_ff [3];
   logic signed [64:0] dh3_ff [3], dl3_ff [3], th3_ff [9], tl3_ff [9];
   aff_pkg::adj_type  adj3_ff [9];
   aff_pkg::wide_type dt4_ff [3], tt4_ff [9];
   aff_pkg::adj_type  adj4_ff [9];
   aff_pkg::cof_type  cof5_ff;

   logic signed [63:0] p1_in [18];
   aff_pkg::adj_type  adj2_in [9];
   logic signed [64:0] dh3_in [3], dl3_in [3], th3_in [9], tl3_in [9];
   aff_pkg::wide_type dt4_in [3], tt4_in [9];
   aff_pkg::cof_type  cof5_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in = (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_cof   = cof5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // products of the 2x2 minors
   always_comb begin
      for (int k = 0; k < 18; k++) p1_in[k] = a0_ff[L_IDX[k]] * a0_ff[R_IDX[k]];
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         adj2_in[k] = {p1_ff[2*k][63], p1_ff[2*k]} - {p1_ff[2*k+1][63], p1_ff[2*k+1]};
      end
   end

   // 32 x 65 products split at bit 32 into two narrow multiplies
   always_comb begin
      logic signed [32:0] hi, lo;
      for (int j = 0; j < 3; j++) begin
         hi = signed'(adj2_ff[j*3][64:32]);
         lo = signed'({1'b0, adj2_ff[j*3][31:0]});
         dh3_in[j] = c2_a_ff[j] * hi;
         dl3_in[j] = c2_a_ff[j] * lo;
      end
      for (int m = 0; m < 9; m++) begin
         hi = signed'(adj2_ff[m][64:32]);
         lo = signed'({1'b0, adj2_ff[m][31:0]});
         th3_in[m] = c2_t_ff[m%3] * hi;
         tl3_in[m] = c2_t_ff[m%3] * lo;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dt4_in[j] = {dh3_ff[j], 32'b0} + {{32{dl3_ff[j][64]}}, dl3_ff[j]};
      end
      for (int m = 0; m < 9; m++) begin
         tt4_in[m] = {th3_ff[m], 32'b0} + {{32{tl3_ff[m][64]}}, tl3_ff[m]};
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) cof5_in.adj[k] = adj4_ff[k];
      cof5_in.det = dt4_ff[0] + dt4_ff[1] + dt4_ff[2];
      for (int i = 0; i < 3; i++) begin
         cof5_in.tsum[i] = tt4_ff[i*3] + tt4_ff[i*3+1] + tt4_ff[i*3+2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 12; k++) a0_ff[k] <= in_data[k*aff_pkg::AW +: aff_pkg::AW];
      end
      if (en[1]) begin
         p1_ff <= p1_in;
         for (int j = 0; j < 3; j++) begin
            c1_a_ff[j] <= a0_ff[j];
            c1_t_ff[j] <= a0_ff[9+j];
         end
      end
      if (en[2]) begin
         adj2_ff <= adj2_in;
         c2_a_ff <= c1_a_ff;
         c2_t_ff <= c1_t_ff;
      end
      if (en[3]) begin
         dh3_ff  <= dh3_in;
         dl3_ff  <= dl3_in;
         th3_ff  <= th3_in;
         tl3_ff  <= tl3_in;
         adj3_ff <= adj2_ff;
      end
      if (en[4]) begin
         dt4_ff  <= dt4_in;
         tt4_ff  <= tt4_in;
         adj4_ff <= adj3_ff;
      end
      if (en[5]) begin
         cof5_ff <= cof5_in;
      end
   end

endmodule

// ----- rtl/core/aff_rowgen.sv -----
// Row sequencer: holds one item and issues its four numerator rows.
module aff_rowgen #(
   parameter  int FRAC_BITS = aff_pkg::DEF_FRAC_BITS,
   localparam int NUM_W = (aff_pkg::ADJ_W + 2*FRAC_BITS > aff_pkg::TS_W + FRAC_BITS) ?
                          aff_pkg::ADJ_W + 2*FRAC_BITS : aff_pkg::TS_W + FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  aff_pkg::cof_type         in_cof,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [NUM_W-1:0]  out_num [3],
   output aff_pkg::wide_type        out_det,
   output aff_pkg::tag_type         out_tag
);

   logic                    h_v_ff, h_v_in;
   logic [1:0]              row_ff, row_in;
   aff_pkg::cof_type        cof_ff;
   logic                    o_v_ff, o_v_in;
   logic signed [NUM_W-1:0] num_ff [3], num_in [3];
   aff_pkg::wide_type       det_ff;
   aff_pkg::tag_type        tag_ff, tag_in;
   logic                    o_en, emit, load, at_last;

   assign o_en     = !o_v_ff || out_ready;
   assign emit     = h_v_ff && o_en;
   assign at_last  = (row_ff == aff_pkg::TRANS_ROW);
   assign in_ready = !h_v_ff || (emit && at_last);
   assign load     = in_valid && in_ready;

   always_comb begin
      h_v_in = h_v_ff;
      row_in = row_ff;
      if (load) begin
         h_v_in = 1'b1;
         row_in = aff_pkg::FIRST_ROW;
      end else if (emit) begin
         h_v_in = !at_last;
         row_in = row_ff + 2'd1;
      end
      o_v_in = o_en ? emit : o_v_ff;
   end

   always_comb begin
      aff_pkg::adj_type  a;
      aff_pkg::wide_type ts;
      logic [NUM_W-1:0]  x;
      for (int j = 0; j < 3; j++) begin
         a  = cof_ff.adj[j];
         case (row_ff)
            2'd1:    a = cof_ff.adj[3+j];
            2'd2:    a = cof_ff.adj[6+j];
            default: a = cof_ff.adj[j];
         endcase
         ts = cof_ff.tsum[j];
         if (at_last) begin
            x         = {{(NUM_W-aff_pkg::TS_W){ts[aff_pkg::TS_W-1]}}, ts} << FRAC_BITS;
            num_in[j] = signed'(NUM_W'(0) - x);
         end else begin
            x         = {{(NUM_W-aff_pkg::ADJ_W){a[aff_pkg::ADJ_W-1]}}, a} << (2*FRAC_BITS);
            num_in[j] = signed'(x);
         end
      end
      tag_in.row_index = row_ff;
      tag_in.singular  = (cof_ff.det == '0);
      tag_in.last_row  = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         row_ff <= aff_pkg::FIRST_ROW;
      end else begin
         h_v_ff <= h_v_in;
         o_v_ff <= o_v_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cof_ff <= in_cof;
      if (emit) begin
         num_ff <= num_in;
         det_ff <= cof_ff.det;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_num   = num_ff;
   assign out_det   = det_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- rtl/core/aff_divider.sv -----
// Three-lane pipelined restoring divider with rounding and saturation.
module aff_divider #(
   parameter  int FRAC_BITS = aff_pkg::DEF_FRAC_BITS,
   localparam int NUM_W = (aff_pkg::ADJ_W + 2*FRAC_BITS > aff_pkg::TS_W + FRAC_BITS) ?
                          aff_pkg::ADJ_W + 2*FRAC_BITS : aff_pkg::TS_W + FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [NUM_W-1:0]       in_num [3],
   input  aff_pkg::wide_type             in_det,
   input  aff_pkg::tag_type              in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [aff_pkg::QW-1:0]        out_col [3],
   output aff_pkg::tag_type              out_tag,
   output logic                          out_clipped
);

   localparam int QW = aff_pkg::QW;
   localparam int DW = aff_pkg::DET_W;
   localparam int CW = (NUM_W > DW + QW) ? NUM_W : DW + QW;
   localparam int NS = QW + 4;   // entry, pre-check, QW bit steps, round, output

   logic [NS-1:0] v_ff, v_in, en;

   // entry stage
   logic [NUM_W-1:0] e_n_ff [3], e_n_in [3];
   logic [DW-1:0]    e_d_ff, e_d_in;
   logic [2:0]       e_neg_ff, e_neg_in;
   aff_pkg::tag_type e_tag_ff;

   // s[0] is the pre-check, s[1..QW] the quotient bits from the top down
   logic [CW-1:0]    s_r_ff   [QW+1][3];
   logic [QW-1:0]    s_q_ff   [QW+1][3];
   logic [DW-1:0]    s_d_ff   [QW+1];
   logic [2:0]       s_neg_ff [QW+1];
   logic [2:0]       s_clip_ff[QW+1];
   aff_pkg::tag_type s_tag_ff [QW+1];

   logic [QW:0]      r_q_ff [3], r_q_in [3];
   logic [2:0]       r_neg_ff, r_clip_ff;
   aff_pkg::tag_type r_tag_ff;

   logic [QW-1:0]    o_col_ff [3], o_col_in [3];
   logic             o_clip_ff, o_clip_in;
   aff_pkg::tag_type o_tag_ff;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in = (en & {v_ff[NS-2:0], in_valid}) | (~en & v_ff);
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e_n_in[j]   = in_num[j][NUM_W-1] ? (~in_num[j] + 1'b1) : in_num[j];
         e_neg_in[j] = in_num[j][NUM_W-1] ^ in_det[DW-1];
      end
      e_d_in = in_det[DW-1] ? (~in_det + 1'b1) : in_det;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e_n_ff   <= e_n_in;
         e_d_ff   <= e_d_in;
         e_neg_ff <= e_neg_in;
         e_tag_ff <= in_tag;
      end
   end

   // pre-check: a quotient of 2^QW or more saturates whatever its sign
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int j = 0; j < 3; j++) begin
            s_r_ff[0][j]    <= CW'(e_n_ff[j]);
            s_q_ff[0][j]    <= '0;
            s_clip_ff[0][j] <= (CW'(e_n_ff[j]) >= CW'({e_d_ff, {QW{1'b0}}}));
         end
         s_d_ff[0]   <= e_d_ff;
         s_neg_ff[0] <= e_neg_ff;
         s_tag_ff[0] <= e_tag_ff;
      end
   end

   for (genvar i = 1; i <= QW; i++) begin : g_step
      localparam int K = QW - i;
      logic [CW-1:0] dk;
      logic [CW-1:0] r_in [3];
      logic [QW-1:0] q_in [3];

      always_comb begin
         logic ge;
         dk = CW'(s_d_ff[i-1]) << K;
         for (int j = 0; j < 3; j++) begin
            ge      = (s_r_ff[i-1][j] >= dk);
            r_in[j] = ge ? (s_r_ff[i-1][j] - dk) : s_r_ff[i-1][j];
            q_in[j] = s_q_ff[i-1][j] | (QW'(ge) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (en[1+i]) begin
            s_r_ff[i]    <= r_in;
            s_q_ff[i]    <= q_in;
            s_d_ff[i]    <= s_d_ff[i-1];
            s_neg_ff[i]  <= s_neg_ff[i-1];
            s_clip_ff[i] <= s_clip_ff[i-1];
            s_tag_ff[i]  <= s_tag_ff[i-1];
         end
      end
   end

   // round half away from zero on the magnitude
   always_comb begin
      logic inc;
      for (int j = 0; j < 3; j++) begin
         inc     = ({s_r_ff[QW][j][DW-1:0], 1'b0} >= {1'b0, s_d_ff[QW]});
         r_q_in[j] = {1'b0, s_q_ff[QW][j]} + (QW+1)'(inc);
      end
   end

   always_ff @(posedge clock) begin
      if (en[QW+2]) begin
         r_q_ff    <= r_q_in;
         r_neg_ff  <= s_neg_ff[QW];
         r_clip_ff <= s_clip_ff[QW];
         r_tag_ff  <= s_tag_ff[QW];
      end
   end

   always_comb begin
      logic [QW:0]   limit;
      logic [QW-1:0] mag;
      logic          c;
      o_clip_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         limit = r_neg_ff[j] ? (QW+1)'(1) << (QW-1) : ((QW+1)'(1) << (QW-1)) - 1'b1;
         c     = r_clip_ff[j] || (r_q_ff[j] > limit);
         mag   = c ? limit[QW-1:0] : r_q_ff[j][QW-1:0];
         o_col_in[j] = r_neg_ff[j] ? (QW'(0) - mag) : mag;
         if (r_tag_ff.singular) o_col_in[j] = '0;
         o_clip_in = o_clip_in | (c && !r_tag_ff.singular);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         o_col_ff  <= o_col_in;
         o_clip_ff <= o_clip_in;
         o_tag_ff  <= r_tag_ff;
      end
   end

   assign out_valid   = v_ff[NS-1];
   assign out_col     = o_col_ff;
   assign out_tag     = o_tag_ff;
   assign out_clipped = o_clip_ff;

endmodule

// ----- rtl/core/affine_matrix_inverse.sv -----
// Inverts a 3x4 affine transform given in signed fixed point (FRAC_BITS fraction bits).
// Each accepted transaction yields four result rows, the three rows of the inverse matrix
// and then the inverse translation, marked by tlast. When the result side keeps up, the
// row sequencer issues one row per cycle into a single divider pipeline, and that is the
// sustained limit: the next item is taken as the previous one issues its last row. From
// input to the first row the path runs through 6 cofactor stages, 2 sequencer stages and
// 36 divider stages. A zero determinant gives zero rows with the singular flag; saturated
// elements raise the clipped flag for their row.
module affine_matrix_inverse #(
   parameter int FRAC_BITS = aff_pkg::DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // a00 a01 a02 a10 a11 a12 a20 a21 a22 shift_x shift_y shift_z, 32 bits each
   input  logic [aff_pkg::IN_W-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // col0 col1 col2, 32 bits each
   output logic [3*aff_pkg::QW-1:0]   rsp_tdata,
   // row_index[1:0] singular clipped
   output logic [3:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int NUM_W = (aff_pkg::ADJ_W + 2*FRAC_BITS > aff_pkg::TS_W + FRAC_BITS) ?
                          aff_pkg::ADJ_W + 2*FRAC_BITS : aff_pkg::TS_W + FRAC_BITS;

   logic                    cof_valid, cof_ready;
   aff_pkg::cof_type        cof;
   logic                    row_valid, row_ready;
   logic signed [NUM_W-1:0] row_num [3];
   aff_pkg::wide_type       row_det;
   aff_pkg::tag_type        row_tag;
   logic [aff_pkg::QW-1:0]  col [3];
   aff_pkg::tag_type        tag;
   logic                    clipped;

   aff_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_cof   (cof)
   );

   aff_rowgen #(.FRAC_BITS(FRAC_BITS)) u_rowgen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_cof    (cof),
      .out_valid (row_valid),
      .out_ready (row_ready),
      .out_num   (row_num),
      .out_det   (row_det),
      .out_tag   (row_tag)
   );

   aff_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (row_valid),
      .in_ready    (row_ready),
      .in_num      (row_num),
      .in_det      (row_det),
      .in_tag      (row_tag),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_col     (col),
      .out_tag     (tag),
      .out_clipped (clipped)
   );

   assign rsp_tdata = {col[2], col[1], col[0]};
   assign rsp_tuser = {clipped, tag.singular, tag.row_index};
   assign rsp_tlast = tag.last_row;

endmodule
